// ===== hw/rtl/per_thread_call_timer_stack_core_assert.svh =====
// Assertion helpers for the call timer stack.
`ifndef PER_THREAD_CALL_TIMER_STACK_CORE_ASSERT_SVH
`define PER_THREAD_CALL_TIMER_STACK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PTCTS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PTCTS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ptcts_pkg.sv =====
package ptcts_pkg;

  // Field widths of the event and result channels
  localparam int unsigned TID_W   = 22;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned DEPTH_W = 6;

  // Result status codes
  typedef enum logic [2:0] {
    ST_PUSHED     = 3'd0,
    ST_DONE       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_STACK_FULL = 3'd4
  } status_t;

  // One open call as held in the stack memory
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [ADDR_W-1:0] call_address;
  } frame_t;

endpackage

// ===== hw/rtl/per_thread_call_timer_stack_core.sv =====
// Per-thread shadow call stack with call timers.
//
// Input channel (in_valid / in_stall): one function entry (in_mode 0) or
// return (in_mode 1) request per accepted cycle, with thread id, timestamp
// and function address. Output channel (out_valid / out_stall): exactly one
// result request per event, in event order: pushed, completed timer, or one
// of the error statuses (no open call, thread table full, stack full).
//
// Throughput is one event per cycle while the receiver does not stall. The
// thread lookup (a parallel compare of all slot tags plus a lowest-free-slot
// pick) and the single stack memory access are done in the cycle of
// acceptance; the registered memory read feeds the result register when the
// middle stage advances, and the result register drives out_valid.
//
// Reset clears the slot valid bits, the open counts and both pipeline
// stages; the stack memory itself is not cleared and needs no clearing pass.
// When the receiver stalls, the result register holds, then the middle
// stage fills, and from then on in_stall follows out_stall.
module per_thread_call_timer_stack_core
  import ptcts_pkg::*;
#(
  parameter int unsigned THREAD_SLOTS = 16,
  parameter int unsigned STACK_DEPTH  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // event channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [TID_W-1:0]   in_thread_id,
  input  logic [TIME_W-1:0]  in_timestamp,
  input  logic [ADDR_W-1:0]  in_function_address,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [TID_W-1:0]   out_thread_out,
  output logic [TIME_W-1:0]  out_start_time,
  output logic [TIME_W-1:0]  out_end_time,
  output logic [DEPTH_W-1:0] out_nesting_depth,
  output logic [ADDR_W-1:0]  out_call_address
);

`include "per_thread_call_timer_stack_core_assert.svh"

  localparam int unsigned SLOT_W    = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = THREAD_SLOTS * STACK_DEPTH;
  localparam int unsigned MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Thread table
  logic [TID_W-1:0]  tags_r [THREAD_SLOTS];
  logic [TID_W-1:0]  tags_nxt [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]  cnt_r [THREAD_SLOTS];
  logic [CNT_W-1:0]  cnt_nxt [THREAD_SLOTS];

  // Stack memory
  frame_t            mem [MEM_DEPTH];
  frame_t            rd_r;

  // Middle stage
  logic              s1_v_r;
  status_t           s1_status_r;
  logic [TID_W-1:0]  s1_tid_r;
  logic [TIME_W-1:0] s1_ts_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [CNT_W-1:0]  s1_level_r;

  // Result register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [TID_W-1:0]   out_tid_r;
  logic [TIME_W-1:0]  out_start_r;
  logic [TIME_W-1:0]  out_end_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic [ADDR_W-1:0]  out_addr_r;

  // Lookup
  logic [THREAD_SLOTS-1:0] hit_vec;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              any_free;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] sel_slot;
  logic [CNT_W-1:0]  sel_cnt;
  logic [CNT_W-1:0]  level;
  status_t           status;
  logic [MEM_AW-1:0] mem_addr;
  logic              in_accept;
  logic              s1_adv;

  // Flow control
  assign s1_adv    = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_v_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Tag match and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    any_free = 1'b0;
    for (int s = 0; s < THREAD_SLOTS; s++) begin
      hit_vec[s] = used_r[s] && (tags_r[s] == in_thread_id);
      if (hit_vec[s]) hit_idx = hit_idx | SLOT_W'(s);
    end
    for (int s = THREAD_SLOTS - 1; s >= 0; s--) begin
      if (!used_r[s]) begin
        free_idx = SLOT_W'(s);
        any_free = 1'b1;
      end
    end
    hit = |hit_vec;
  end

  // Event decode
  always_comb begin
    sel_slot = hit ? hit_idx : free_idx;
    sel_cnt  = hit ? cnt_r[hit_idx] : '0;
    level    = sel_cnt;
    if (in_mode) begin
      if (!hit || sel_cnt == '0) begin
        status = ST_EMPTY;
      end else begin
        status = ST_DONE;
        level  = sel_cnt - CNT_W'(1);
      end
    end else if (!hit && !any_free) begin
      status = ST_TABLE_FULL;
    end else if (sel_cnt >= CNT_W'(STACK_DEPTH)) begin
      status = ST_STACK_FULL;
    end else begin
      status = ST_PUSHED;
    end
    mem_addr = MEM_AW'(sel_slot) * MEM_AW'(STACK_DEPTH) + MEM_AW'(level);
  end

  // Table update
  always_comb begin
    tags_nxt = tags_r;
    used_nxt = used_r;
    cnt_nxt  = cnt_r;
    if (in_accept) begin
      case (status)
        ST_PUSHED: begin
          used_nxt[sel_slot] = 1'b1;
          tags_nxt[sel_slot] = in_thread_id;
          cnt_nxt[sel_slot]  = sel_cnt + CNT_W'(1);
        end
        ST_DONE: begin
          cnt_nxt[sel_slot] = level;
          if (level == '0) used_nxt[sel_slot] = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int s = 0; s < THREAD_SLOTS; s++) begin
        tags_r[s] <= '0;
        cnt_r[s]  <= '0;
      end
    end else begin
      used_r <= used_nxt;
      tags_r <= tags_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Stack memory: push writes, pop reads
  always_ff @(posedge clk) begin
    if (in_accept && status == ST_PUSHED)
      mem[mem_addr] <= '{start_time: in_timestamp, call_address: in_function_address};
    if (in_accept && status == ST_DONE) rd_r <= mem[mem_addr];
  end

  // Middle stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
    if (in_accept) begin
      s1_status_r <= status;
      s1_tid_r    <= in_thread_id;
      s1_ts_r     <= in_timestamp;
      s1_addr_r   <= in_function_address;
      s1_level_r  <= level;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      out_tid_r    <= s1_tid_r;
      case (s1_status_r)
        ST_PUSHED: begin
          out_start_r <= s1_ts_r;
          out_end_r   <= '0;
          out_depth_r <= DEPTH_W'(s1_level_r);
          out_addr_r  <= s1_addr_r;
        end
        ST_DONE: begin
          out_start_r <= rd_r.start_time;
          out_end_r   <= s1_ts_r;
          out_depth_r <= DEPTH_W'(s1_level_r);
          out_addr_r  <= rd_r.call_address;
        end
        default: begin
          out_start_r <= '0;
          out_end_r   <= '0;
          out_depth_r <= '0;
          out_addr_r  <= '0;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_thread_out    = out_tid_r;
  assign out_start_time    = out_start_r;
  assign out_end_time      = out_end_r;
  assign out_nesting_depth = out_depth_r;
  assign out_call_address  = out_addr_r;

  // Table consistency: a used slot has open calls, a free one has none
  logic cnt_bad;
  always_comb begin
    cnt_bad = 1'b0;
    for (int s = 0; s < THREAD_SLOTS; s++) begin
      if (cnt_r[s] > CNT_W'(STACK_DEPTH)) cnt_bad = 1'b1;
      if (used_r[s] != (cnt_r[s] != '0)) cnt_bad = 1'b1;
    end
  end

  `PTCTS_ASSERT_NOW(a_table_consistent, clk, rst_n, 1'b1, !cnt_bad)
  `PTCTS_ASSERT_NOW(a_tag_unique, clk, rst_n, 1'b1, $onehot0(hit_vec))
  `PTCTS_ASSERT_NEXT(a_push_marks_used, clk, rst_n, in_accept && status == ST_PUSHED,
                     used_r[$past(sel_slot)])
  `PTCTS_ASSERT_NEXT(a_mid_holds, clk, rst_n, s1_v_r && !s1_adv,
                     s1_v_r && $stable(s1_tid_r) && $stable(rd_r))

endmodule
